// ===== rtl/core/bol_pkg.sv =====
// Package for the bounded ordered list: sizes, command codes and the control
// bundle that the top level hands to every list cell.
// No dependencies.
package bol_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int FILL_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [2:0]       ADDR_CAP  = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [POS_W-1:0]       pos;
        logic [CNT_W-1:0]       cnt;
        logic [VAL_W-1:0]       value;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/bounded_ordered_list_top.sv =====
// Top level of the bounded ordered list: command decode, fill count,
// capacity register, result register and the row of list cells.
// Depends on bol_pkg and bol_cell.
//
//  channel     | direction | payload
//  s_axis      | in        | tuser: cmd; tdata: position, entry_value
//  m_axis      | out       | tuser: ok; tdata: read_value, fill_count, is_empty
//  apb         | in/out    | register 0 capacity_limit at byte address 0
//
// All cells shift in parallel at the edge that accepts the transfer, and the
// result register holds the outcome.
// A new command is taken whenever the result register is empty or being read,
// so one command per cycle is sustained while the output is not stalled.
// Reset clears the fill count, the result valid flag and sets the capacity to 16.
// The entries themselves are not reset.
module bounded_ordered_list_top
    import bol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    input  logic [39:0] s_axis_tdata,   // position[4:0], entry_value[36:5], zero[39:37]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [0:0]  m_axis_tuser,   // ok[0]
    output logic [39:0] m_axis_tdata,   // read_value[31:0], fill_count[36:32],
                                        // is_empty[37], zero[39:38]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_rd;

    logic              w_accept;
    logic [CMD_W-1:0]  w_cmd;
    logic [POS_W-1:0]  w_pos;
    logic [VAL_W-1:0]  w_val;
    logic [CNT_W-1:0]  w_cap_eff;
    logic              w_room;
    logic              w_ok;
    logic              w_read;
    logic [VAL_W-1:0]  w_rd_any;
    t_cell_op          w_op;
    t_cell_ctrl        w_ctrl;

    logic [VAL_W-1:0]  w_cell_val   [DEPTH];
    logic [VAL_W-1:0]  w_cell_match [DEPTH];
    logic [VAL_W-1:0]  w_cell_left  [DEPTH];
    logic [VAL_W-1:0]  w_cell_right [DEPTH];

    assign w_cmd = s_axis_tuser;
    assign w_pos = s_axis_tdata[POS_W-1:0];
    assign w_val = VAL_W'(s_axis_tdata[POS_W+DATA_W-1:POS_W]);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_cap_eff = (CNT_W'(r_cap) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(r_cap);
    assign w_room    = r_count < w_cap_eff;

    always_comb begin
        w_ok    = 1'b0;
        w_read  = 1'b0;
        w_op    = CELL_HOLD;
        n_count = r_count;
        unique case (w_cmd)
            CMD_APPEND: begin
                w_ok = w_room;
                w_op = CELL_APPEND;
                if (w_room) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                w_ok = w_room && (w_pos <= POS_W'(r_count));
                w_op = CELL_INSERT;
                if (w_ok) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_ERASE: begin
                w_ok = w_pos < POS_W'(r_count);
                w_op = CELL_ERASE;
                if (w_ok) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_READ: begin
                w_ok   = w_pos < POS_W'(r_count);
                w_read = w_ok;
            end
            CMD_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctrl.op    = (w_accept && w_ok) ? w_op : CELL_HOLD;
        w_ctrl.pos   = w_pos;
        w_ctrl.cnt   = r_count;
        w_ctrl.value = w_val;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_cell_left[g] = '0;
            end else begin : g_mid_l
                assign w_cell_left[g] = w_cell_val[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_cell_right[g] = w_cell_val[g];
            end else begin : g_mid_r
                assign w_cell_right[g] = w_cell_val[g+1];
            end
            bol_cell u_cell (
                .i_clk         (i_clk),
                .i_index       (IDX_W'(g)),
                .i_ctrl        (w_ctrl),
                .i_left        (w_cell_left[g]),
                .i_right       (w_cell_right[g]),
                .o_value       (w_cell_val[g]),
                .o_match_value (w_cell_match[g])
            );
        end
    endgenerate

    always_comb begin
        w_rd_any = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_any = w_rd_any | w_cell_match[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok <= w_ok;
            r_rd <= w_read ? DATA_W'(w_rd_any) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAP)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAP) ? 32'(r_cap) : '0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_ok;
    assign m_axis_tdata  = {2'b00, (r_count == '0), FILL_W'(r_count), r_rd};

endmodule

// ===== rtl/core/bol_cell.sv =====
// One list cell: holds a single entry and takes a new value from the command,
// from its lower neighbor or from its upper neighbor.
// Depends on bol_pkg.
module bol_cell
    import bol_pkg::*;
(
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_index,
    input  t_cell_ctrl        i_ctrl,
    input  logic [VAL_W-1:0]  i_left,
    input  logic [VAL_W-1:0]  i_right,
    output logic [VAL_W-1:0]  o_value,
    output logic [VAL_W-1:0]  o_match_value
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic [POS_W-1:0] w_idx_pos;
    logic [CNT_W-1:0] w_idx_cnt;

    assign w_idx_pos = POS_W'(i_index);
    assign w_idx_cnt = CNT_W'(i_index);

    always_comb begin
        n_value = r_value;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
                n_value = r_value;
            end
            CELL_APPEND: begin
                if (w_idx_cnt == i_ctrl.cnt) begin
                    n_value = i_ctrl.value;
                end
            end
            CELL_INSERT: begin
                if (w_idx_pos > i_ctrl.pos) begin
                    n_value = i_left;
                end else if (w_idx_pos == i_ctrl.pos) begin
                    n_value = i_ctrl.value;
                end
            end
            CELL_ERASE: begin
                if (w_idx_pos >= i_ctrl.pos) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value       = r_value;
    assign o_match_value = (w_idx_pos == i_ctrl.pos) ? r_value : '0;

endmodule

// ===== rtl/core/bol_checker.sv =====
// Port-level checker for the bounded ordered list, bound to the top level.
// Depends on the port list of bounded_ordered_list_top.
module bol_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [0:0]  m_axis_tuser,
    input logic [39:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("Rejected command returned a nonzero read value.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[37] == (m_axis_tdata[36:32] == 5'd0))
        else $error("Empty flag disagrees with the fill count.");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:32] <= 5'd16)
        else $error("Fill count exceeds the list depth.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result valid after reset.");

endmodule

bind bounded_ordered_list_top bol_checker u_bol_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);
